/* src/mbrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU slave package
// Shared types, constants and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package mbrs_pkg;

  localparam int unsigned FrameDepthDef = 128;
  localparam int unsigned MaxRegsDef    = 29;
  localparam int unsigned KW            = 6;  // reply byte index, up to 2*29+4

  localparam logic [7:0]  SlaveIdRst   = 8'd1;
  localparam logic [15:0] TimeoutRst   = 16'd3880;
  localparam logic [15:0] ReadValueRst = 16'h4567;
  localparam logic [7:0]  FuncReadHold = 8'd3;
  localparam logic [7:0]  AddrBcast    = 8'd0;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'hA001;
  localparam logic [15:0] SilenceMax   = 16'hFFFF;

  typedef enum logic [1:0] {
    REG_SLAVE_ID  = 2'd0,
    REG_TIMEOUT   = 2'd1,
    REG_READ_VAL  = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* src/mbrs_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive channel
// Valid/ready channel carrying a received byte or a timer tick.
// ----------------------------------------------------------------------------
interface mbrs_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

/* src/mbrs_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transmit channel
// Valid/ready channel carrying reply bytes and frame status.
// ----------------------------------------------------------------------------
interface mbrs_out_if;
  logic        valid;
  logic        ready;
  logic        byte_valid;
  logic [7:0]  tx_byte;
  logic        last;
  logic [15:0] error_count;

  modport source (output valid, output byte_valid, output tx_byte, output last,
                  output error_count, input ready);
  modport sink   (input valid, input byte_valid, input tx_byte, input last,
                  input error_count, output ready);
endinterface

/* src/modbus_rtu_slave_read_holding.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU slave, read holding registers
// Collects frame bytes in a memory, detects end of frame by silence, checks
// the CRC and answers function 3 with a fixed register value.
// ----------------------------------------------------------------------------
//  channel  dir  transaction
//  rx_i     in   func (byte/tick), rx_byte
//  tx_o     out  byte_valid, tx_byte, last, error_count
//  cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// A byte or a tick that does not end a frame leaves the slave idle and ready.
// A frame end of more than six bytes reads the byte memory once, one byte per
// cycle; a shorter frame goes straight to judgement. Then one result per
// cycle is emitted while tx_o is ready.
// No new transaction is taken on rx_i until the last result is loaded.
// Reset clears counters and the timer; the memory is not cleared.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_read_holding
  import mbrs_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = FrameDepthDef,
  parameter int unsigned MAX_REGS    = MaxRegsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mbrs_in_if.sink     rx_i,
  mbrs_out_if.source  tx_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(FRAME_DEPTH);
  localparam int unsigned CW = $clog2(FRAME_DEPTH + 1);
  localparam logic [CW-1:0] Depth = CW'(FRAME_DEPTH);

  state_e state_q, state_d;

  logic [7:0]    slave_id_q;
  logic [15:0]   timeout_q, read_val_q;
  logic [CW-1:0] count_q, rd_q, pidx_q;
  logic [15:0]   silence_q, err_q, crc_q, txcrc_q;
  logic          running_q, pend_q;
  logic [7:0]    b0_q, b1_q, b4_q, b5_q, rxlo_q, rxhi_q, rdata_q;
  logic [4:0]    nregs_q;
  logic          status_q;
  logic [KW-1:0] k_q, klast_q;

  logic [7:0] mem [FRAME_DEPTH];

  logic          rx_fire, tick_end, rd_en, load;
  logic [15:0]   sil_inc;
  logic [KW-1:0] kd;
  logic [7:0]    emit_b;
  logic          reply_ok, err_inc;
  logic [15:0]   nregs16;

  assign rx_fire = rx_i.valid && rx_i.ready;
  assign sil_inc = (silence_q == SilenceMax) ? silence_q : silence_q + 16'd1;
  assign tick_end = rx_fire && rx_i.func && running_q && (sil_inc >= timeout_q);
  assign load = (state_q == ST_EMIT) && (!tx_o.valid || tx_o.ready);
  assign nregs16 = {b4_q, b5_q};

  // frame judgement
  always_comb begin
    reply_ok = 1'b0;
    err_inc  = 1'b0;
    if (count_q > CW'(6)) begin
      if (b0_q == slave_id_q || b0_q == AddrBcast) begin
        if (crc_q != {rxhi_q, rxlo_q}) begin
          err_inc = 1'b1;
        end else if (b0_q != AddrBcast && b1_q == FuncReadHold) begin
          if (nregs16 > 16'(MAX_REGS)) err_inc = 1'b1;
          else reply_ok = 1'b1;
        end
      end
    end else if (count_q != '0) begin
      err_inc = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (tick_end) state_d = (count_q > CW'(6)) ? ST_READ : ST_DECIDE;
      ST_READ:   if (rd_q == count_q - CW'(1)) state_d = ST_DRAIN;
      ST_DRAIN:  if (!pend_q) state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_EMIT;
      ST_EMIT:   if (load && (status_q || k_q == klast_q)) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rx_i.ready = (state_q == ST_IDLE);
    rd_en      = (state_q == ST_READ);
  end

  // reply byte for index k_q
  always_comb begin
    kd = k_q - KW'(3);
    if (k_q == KW'(0))                  emit_b = slave_id_q;
    else if (k_q == KW'(1))             emit_b = FuncReadHold;
    else if (k_q == KW'(2))             emit_b = {2'b00, nregs_q, 1'b0};
    else if (k_q == klast_q - KW'(1))   emit_b = txcrc_q[7:0];
    else if (k_q == klast_q)            emit_b = txcrc_q[15:8];
    else                                emit_b = kd[0] ? read_val_q[7:0] : read_val_q[15:8];
  end

  // byte memory
  always_ff @(posedge clk_i) begin
    if (rx_fire && !rx_i.func && count_q < Depth) mem[count_q[AW-1:0]] <= rx_i.rx_byte;
    if (rd_en) rdata_q <= mem[rd_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      slave_id_q <= SlaveIdRst;
      timeout_q  <= TimeoutRst;
      read_val_q <= ReadValueRst;
      count_q    <= '0;
      silence_q  <= '0;
      running_q  <= 1'b0;
      err_q      <= '0;
      pend_q     <= 1'b0;
      rd_q       <= '0;
      k_q        <= '0;
      tx_o.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_SLAVE_ID: slave_id_q <= cfg_data_i[7:0];
          REG_TIMEOUT:  timeout_q  <= cfg_data_i;
          REG_READ_VAL: read_val_q <= cfg_data_i;
          default:      ;
        endcase
      end
      if (tx_o.valid && tx_o.ready && !load) tx_o.valid <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (rx_fire) begin
            if (!rx_i.func) begin
              if (count_q < Depth) count_q <= count_q + CW'(1);
              silence_q <= '0;
              running_q <= 1'b1;
            end else if (running_q) begin
              silence_q <= sil_inc;
            end
          end
          rd_q  <= '0;
          crc_q <= CrcInit;
        end
        ST_READ: rd_q <= rd_q + CW'(1);
        ST_DECIDE: begin
          err_q     <= err_q + {15'd0, err_inc};
          status_q  <= !reply_ok;
          nregs_q   <= b5_q[4:0];
          klast_q   <= KW'({b5_q[4:0], 1'b0}) + KW'(4);
          txcrc_q   <= CrcInit;
          k_q       <= '0;
          count_q   <= '0;
          silence_q <= '0;
          running_q <= 1'b0;
        end
        ST_EMIT: begin
          if (load) begin
            tx_o.valid       <= 1'b1;
            tx_o.last        <= status_q || k_q == klast_q;
            tx_o.byte_valid  <= !status_q;
            tx_o.tx_byte     <= status_q ? 8'h00 : emit_b;
            tx_o.error_count <= err_q;
            k_q              <= k_q + KW'(1);
            if (k_q < klast_q - KW'(1)) txcrc_q <= crc_add(txcrc_q, emit_b);
          end
        end
        default: ;
      endcase
      pend_q <= rd_en;
      if (rd_en) pidx_q <= rd_q;
      if (pend_q) begin
        if (pidx_q < count_q - CW'(2)) crc_q <= crc_add(crc_q, rdata_q);
        if (pidx_q == CW'(0)) b0_q <= rdata_q;
        if (pidx_q == CW'(1)) b1_q <= rdata_q;
        if (pidx_q == CW'(4)) b4_q <= rdata_q;
        if (pidx_q == CW'(5)) b5_q <= rdata_q;
        if (pidx_q == count_q - CW'(2)) rxlo_q <= rdata_q;
        if (pidx_q == count_q - CW'(1)) rxhi_q <= rdata_q;
      end
    end
  end

  a_busy_no_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !rx_i.ready) else $error("rx ready while busy");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Depth) else $error("byte count beyond store");
  a_judge_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DECIDE |=> count_q == '0 && !running_q) else $error("frame not cleared");
  a_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> rd_q < count_q) else $error("read past frame");

endmodule
